FILE: rtl/core/apf2_pkg.sv
`default_nettype none

package apf2_pkg;

  localparam int CHANNELS    = 8;
  localparam int CHAN_W      = 3;
  localparam int SAMPLE_BITS = 24;
  localparam int COEF_BITS   = 18;

  localparam int FRAC_SHIFT = COEF_BITS - 2;
  localparam int OPND_W     = SAMPLE_BITS + 1;
  localparam int PROD_W     = OPND_W + COEF_BITS;
  localparam int RND_W      = PROD_W - FRAC_SHIFT;
  localparam int SUM_W      = RND_W + 2;
  localparam int CH_AW      = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_W      = COEF_BITS;

  localparam logic [CFG_IDX_W-1:0] CFG_COEF_E1 = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_COEF_E2 = CFG_IDX_W'(1);

  typedef logic        [CHAN_W-1:0]      chan_t;
  typedef logic signed [SAMPLE_BITS-1:0] sample_t;
  typedef logic signed [COEF_BITS-1:0]   coef_t;
  typedef logic        [CH_AW-1:0]       addr_t;

  // per-channel history entry
  typedef struct packed {
    sample_t x1;
    sample_t x2;
    sample_t y1;
    sample_t y2;
  } hist_t;

  localparam int HIST_W = $bits(hist_t);

  function automatic logic chan_ok(chan_t c);
    return int'(c) < CHANNELS;
  endfunction

  function automatic addr_t ch_addr(chan_t c);
    return CH_AW'(c);
  endfunction

endpackage

`default_nettype wire

FILE: rtl/core/apf2_if.sv
`default_nettype none

interface apf2_in_if;
  import apf2_pkg::*;

  logic    valid;
  logic    ready;
  chan_t   chan;
  sample_t sample_in;

  modport source (output valid, output chan, output sample_in, input ready);
  modport sink (input valid, input chan, input sample_in, output ready);
endinterface

interface apf2_out_if;
  import apf2_pkg::*;

  logic    valid;
  logic    ready;
  chan_t   chan_out;
  sample_t sample_out;

  modport source (output valid, output chan_out, output sample_out, input ready);
  modport sink (input valid, input chan_out, input sample_out, output ready);
endinterface

`default_nettype wire

FILE: rtl/core/apf2_ram.sv
`default_nettype none

module apf2_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // read returns the old contents on a same-address write
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

FILE: rtl/core/apf2_dp.sv
`default_nettype none

module apf2_dp (
  input  wire logic             clk_i,
  input  wire logic             ld_i,
  input  wire apf2_pkg::hist_t   hist_i,
  input  wire apf2_pkg::sample_t x_i,
  input  wire apf2_pkg::coef_t   e1_i,
  input  wire apf2_pkg::coef_t   e2_i,
  output apf2_pkg::sample_t      y_o,
  output apf2_pkg::hist_t        wb_o
);
  import apf2_pkg::*;

  logic signed [OPND_W-1:0] s1, s2;
  logic signed [PROD_W-1:0] m1_d, m2_d, m1_q, m2_q;
  logic signed [PROD_W-1:0] t1, t2;
  logic signed [RND_W-1:0]  r1, r2;
  logic signed [SUM_W-1:0]  sum;
  logic                     ovf;
  sample_t                  x_q, x1_q, x2_q, y1_q, y;

  // multiply stage
  assign s1   = OPND_W'(hist_i.x1) + OPND_W'(hist_i.y1);
  assign s2   = OPND_W'(x_i) + OPND_W'(hist_i.y2);
  assign m1_d = PROD_W'(e1_i) * PROD_W'(s1);
  assign m2_d = PROD_W'(e2_i) * PROD_W'(s2);

  always_ff @(posedge clk_i) begin
    if (ld_i) begin
      m1_q <= m1_d;
      m2_q <= m2_d;
      x_q  <= x_i;
      x1_q <= hist_i.x1;
      x2_q <= hist_i.x2;
      y1_q <= hist_i.y1;
    end
  end

  // round half away from zero, sum, saturate
  assign t1  = m1_q + PROD_W'(1 << (FRAC_SHIFT - 1)) - PROD_W'(m1_q[PROD_W-1]);
  assign t2  = m2_q + PROD_W'(1 << (FRAC_SHIFT - 1)) - PROD_W'(m2_q[PROD_W-1]);
  assign r1  = t1[PROD_W-1:FRAC_SHIFT];
  assign r2  = t2[PROD_W-1:FRAC_SHIFT];
  assign sum = -SUM_W'(r1) - SUM_W'(r2) - SUM_W'(x2_q);
  assign ovf = (sum[SUM_W-1:SAMPLE_BITS-1] != '0) && (sum[SUM_W-1:SAMPLE_BITS-1] != '1);

  always_comb begin
    if (ovf) begin
      y = {sum[SUM_W-1], {(SAMPLE_BITS-1){~sum[SUM_W-1]}}};
    end else begin
      y = sum[SAMPLE_BITS-1:0];
    end
  end

  assign y_o = y;

  always_comb begin
    wb_o.x1 = x_q;
    wb_o.x2 = x1_q;
    wb_o.y1 = y;
    wb_o.y2 = y1_q;
  end

endmodule

`default_nettype wire

FILE: rtl/core/multichannel_allpass2_section_top.sv
// channel   direction  payload                 accepted when
// in_ch     sink       chan, sample_in         in_ch.valid && in_ch.ready
// out_ch    source     chan_out, sample_out    out_ch.valid && out_ch.ready
// cfg       write      cfg_idx_i, cfg_wdata_i  cfg_we_i
//
// one transaction per cycle unless stalled; each goes through the product registers to the
// output register; one on the same channel as the one directly ahead waits in the multiply
// stage until that one writes back, as y1, the previous result, feeds the e1 multiplier
// history lives in one ram entry per channel; per-channel valid bits clear it at reset at once
// a stalled output holds the pipeline and drops in_ch.ready once stage one cannot move
`default_nettype none

module multichannel_allpass2_section_top (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  apf2_in_if.sink                             in_ch,
  apf2_out_if.source                          out_ch,
  input  wire logic                           cfg_we_i,
  input  wire logic [apf2_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  wire logic [apf2_pkg::CFG_W-1:0]     cfg_wdata_i
);
  import apf2_pkg::*;

  coef_t               coef_e1_q, coef_e2_q;
  logic                in_acc;
  logic                p1_vld_q, p1_vld_d, p1_adv, hazard;
  chan_t               p1_chan_q;
  sample_t             p1_x_q;
  logic                rdv_q;
  logic                fwd_vld_q, fwd_vld_d, fwd_hit;
  hist_t               fwd_q, hist1, ram_rdata, wb;
  chan_t               nxt_chan;
  logic                p2_vld_q, p2_vld_d, p2_ok_q, p2_adv;
  chan_t               p2_chan_q;
  logic                out_vld_q, out_vld_d, out_free;
  chan_t               out_chan_q;
  sample_t             out_y_q, y;
  logic                we;
  logic [CHANNELS-1:0] vld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coef_e1_q <= '0;
      coef_e2_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_COEF_E1: coef_e1_q <= cfg_wdata_i;
        CFG_COEF_E2: coef_e2_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // pipeline control
  assign in_acc   = in_ch.valid && in_ch.ready;
  assign out_free = !out_vld_q || out_ch.ready;
  assign p2_adv   = p2_vld_q && out_free;
  assign hazard   = p2_vld_q && p2_ok_q && (p2_chan_q == p1_chan_q);
  assign p1_adv   = p1_vld_q && (!p2_vld_q || p2_adv) && !hazard;
  assign in_ch.ready = !p1_vld_q || p1_adv;
  assign we       = p2_adv && p2_ok_q;

  assign p1_vld_d  = in_acc ? 1'b1 : (p1_adv ? 1'b0 : p1_vld_q);
  assign p2_vld_d  = p1_adv ? 1'b1 : (p2_adv ? 1'b0 : p2_vld_q);
  assign out_vld_d = p2_adv ? 1'b1 : (out_ch.ready ? 1'b0 : out_vld_q);

  // forward a writeback that the ram read of the stage-one entry missed
  assign nxt_chan = in_acc ? in_ch.chan : p1_chan_q;
  assign fwd_hit  = we && (p2_chan_q == nxt_chan);

  always_comb begin
    fwd_vld_d = fwd_vld_q;
    if (fwd_hit) begin
      fwd_vld_d = 1'b1;
    end else if (in_acc) begin
      fwd_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p1_vld_q  <= 1'b0;
      p2_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
      fwd_vld_q <= 1'b0;
      rdv_q     <= 1'b0;
      vld_q     <= '0;
    end else begin
      p1_vld_q  <= p1_vld_d;
      p2_vld_q  <= p2_vld_d;
      out_vld_q <= out_vld_d;
      fwd_vld_q <= fwd_vld_d;
      if (in_acc) begin
        rdv_q <= vld_q[ch_addr(in_ch.chan)];
      end
      if (we) begin
        vld_q[ch_addr(p2_chan_q)] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      p1_chan_q <= in_ch.chan;
      p1_x_q    <= in_ch.sample_in;
    end
    if (fwd_hit) begin
      fwd_q <= wb;
    end
    if (p1_adv) begin
      p2_chan_q <= p1_chan_q;
      p2_ok_q   <= chan_ok(p1_chan_q);
    end
    if (p2_adv) begin
      out_chan_q <= p2_chan_q;
      out_y_q    <= p2_ok_q ? y : '0;
    end
  end

  always_comb begin
    if (fwd_vld_q) begin
      hist1 = fwd_q;
    end else if (rdv_q) begin
      hist1 = ram_rdata;
    end else begin
      hist1 = '0;
    end
  end

  apf2_ram #(
    .WIDTH (HIST_W),
    .DEPTH (CHANNELS)
  ) u_hist_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (ch_addr(p2_chan_q)),
    .wdata_i (wb),
    .re_i    (in_acc),
    .raddr_i (ch_addr(in_ch.chan)),
    .rdata_o (ram_rdata)
  );

  apf2_dp u_dp (
    .clk_i  (clk_i),
    .ld_i   (p1_adv),
    .hist_i (hist1),
    .x_i    (p1_x_q),
    .e1_i   (coef_e1_q),
    .e2_i   (coef_e2_q),
    .y_o    (y),
    .wb_o   (wb)
  );

  assign out_ch.valid      = out_vld_q;
  assign out_ch.chan_out   = out_chan_q;
  assign out_ch.sample_out = out_y_q;

endmodule

`default_nettype wire

FILE: rtl/core/apf2_checker.sv
`default_nettype none

module apf2_checker (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  apf2_in_if.sink                             in_ch,
  apf2_out_if.source                          out_ch,
  input  wire logic                           cfg_we_i,
  input  wire logic [apf2_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  wire logic [apf2_pkg::CFG_W-1:0]     cfg_wdata_i
);
  import apf2_pkg::*;

  logic       in_tr, out_tr;
  logic [2:0] cnt_q;

  assign in_tr  = in_ch.valid && in_ch.ready;
  assign out_tr = out_ch.valid && out_ch.ready;

  // transactions inside the block
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_q + 3'(in_tr) - 3'(out_tr);
    end
  end

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_ch.valid && !out_ch.ready |=> out_ch.valid)
    else $error("output valid dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_ch.valid && !out_ch.ready |=>
      $stable(out_ch.chan_out) && $stable(out_ch.sample_out))
    else $error("output payload changed while stalled");

  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_tr |-> cnt_q != 3'd0)
    else $error("result without a pending input");

  a_capacity: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= 3'd3)
    else $error("more transactions in flight than pipeline stages");

  a_cfg_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_we_i |-> (cnt_q == 3'd0) && !$isunknown({cfg_idx_i, cfg_wdata_i}))
    else $error("register write while transactions in flight");

endmodule

bind multichannel_allpass2_section_top apf2_checker u_apf2_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_ch       (in_ch),
  .out_ch      (out_ch),
  .cfg_we_i    (cfg_we_i),
  .cfg_idx_i   (cfg_idx_i),
  .cfg_wdata_i (cfg_wdata_i)
);

`default_nettype wire

FILE: tb/tb.sv
`timescale 1ns / 1ps

module tb;
  import apf2_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int N_PHASES    = 9;
  localparam int PHASE_ITEMS = 142;
  localparam int N_DIRECTED  = 20;

  localparam sample_t S_MAX = 24'sh7FFFFF;
  localparam sample_t S_MIN = 24'sh800000;
  localparam coef_t   C_MAX = 18'sh1FFFF;
  localparam coef_t   C_MIN = 18'sh20000;

  typedef struct packed {
    chan_t   ch;
    sample_t y;
  } result_t;

  typedef struct packed {
    chan_t   ch;
    sample_t x;
    logic    typed;
    sample_t y;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_idx;
  logic [CFG_W-1:0] cfg_wdata;
  logic hold_req = 1'b0;

  apf2_in_if  in_ch ();
  apf2_out_if out_ch ();

  multichannel_allpass2_section_top dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_ch       (in_ch),
    .out_ch      (out_ch),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // filter state as the block should hold it
  coef_t   k1 = '0;
  coef_t   k2 = '0;
  sample_t in_z1  [CHANNELS];
  sample_t in_z2  [CHANNELS];
  sample_t out_z1 [CHANNELS];
  sample_t out_z2 [CHANNELS];

  result_t due_results [$];
  int mismatches = 0;
  int items_sent = 0;
  int results_seen = 0;

  // rows with a typed result run at the reset coefficients, where y is just -x2
  stim_row_t dir_tab [N_DIRECTED] = '{
    '{3'd0, S_MAX,         1'b1, 24'sd0},
    '{3'd7, -24'sd1,       1'b1, 24'sd0},
    '{3'd0, S_MIN,         1'b1, 24'sd0},
    '{3'd7, 24'sd1,        1'b1, 24'sd0},
    '{3'd0, 24'sd0,        1'b1, 24'sh800001},
    '{3'd7, 24'sd0,        1'b1, 24'sd1},
    '{3'd0, 24'sd0,        1'b1, S_MAX},
    '{3'd7, 24'sd0,        1'b1, -24'sd1},
    '{3'd1, 24'sh555555,   1'b0, 24'sd0},
    '{3'd2, 24'shAAAAAA,   1'b0, 24'sd0},
    '{3'd3, S_MIN,         1'b0, 24'sd0},
    '{3'd4, S_MAX,         1'b0, 24'sd0},
    '{3'd5, 24'sd1,        1'b0, 24'sd0},
    '{3'd6, 24'shFFFFFE,   1'b0, 24'sd0},
    '{3'd1, 24'shAAAAAA,   1'b0, 24'sd0},
    '{3'd2, 24'sh555555,   1'b0, 24'sd0},
    '{3'd1, 24'sd0,        1'b0, 24'sd0},
    '{3'd2, 24'sd0,        1'b0, 24'sd0},
    '{3'd3, S_MIN,         1'b0, 24'sd0},
    '{3'd3, 24'sd0,        1'b0, 24'sd0}
  };

  // coefficient times operand, back to Q1.23, rounded half away from zero
  function automatic longint scaled_mul(longint c, longint v);
    logic neg;
    longint unsigned mag;
    neg = (c < 0) != (v < 0);
    mag = longint'(c < 0 ? -c : c) * longint'(v < 0 ? -v : v);
    mag = (mag + (64'd1 << (FRAC_SHIFT - 1))) >> FRAC_SHIFT;
    return neg ? -longint'(mag) : longint'(mag);
  endfunction

  function automatic sample_t allpass_next(chan_t c, sample_t x);
    longint w1, w2, acc;
    sample_t y;
    if (int'(c) >= CHANNELS) return '0;
    w1 = scaled_mul(longint'(k1), longint'(in_z1[c]) + longint'(out_z1[c]));
    w2 = scaled_mul(longint'(k2), longint'(x) + longint'(out_z2[c]));
    acc = -w1 - w2 - longint'(in_z2[c]);
    if (acc > longint'(S_MAX)) y = S_MAX;
    else if (acc < longint'(S_MIN)) y = S_MIN;
    else y = sample_t'(acc);
    in_z2[c]  = in_z1[c];
    out_z2[c] = out_z1[c];
    in_z1[c]  = x;
    out_z1[c] = y;
    return y;
  endfunction

  function automatic sample_t rand_sample();
    case ($urandom_range(0, 11))
      0: return S_MAX;
      1: return S_MIN;
      2: return sample_t'($urandom_range(0, 511)) - sample_t'(256);
      default: return sample_t'($urandom);
    endcase
  endfunction

  function automatic void flag_mismatch(string what, int want, int got);
    mismatches++;
    if (mismatches <= 10) $display("mismatch %s: expected %0d, got %0d", what, want, got);
  endfunction

  task automatic push_item(chan_t c, sample_t x, logic typed, sample_t ty);
    result_t r;
    in_ch.valid     <= 1'b1;
    in_ch.chan      <= c;
    in_ch.sample_in <= x;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    r.ch = c;
    r.y  = allpass_next(c, x);
    if (typed) r.y = ty;
    due_results.push_back(r);
    items_sent++;
  endtask

  task automatic wait_drain();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (due_results.size() != 0);
  endtask

  task automatic write_coefs(coef_t a, coef_t b);
    cfg_we    <= 1'b1;
    cfg_idx   <= CFG_COEF_E1;
    cfg_wdata <= a;
    @(posedge clk);
    cfg_idx   <= CFG_COEF_E2;
    cfg_wdata <= b;
    @(posedge clk);
    cfg_we <= 1'b0;
    k1 = a;
    k2 = b;
  endtask

  always @(posedge clk) begin : result_check
    result_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      results_seen++;
      if (due_results.size() == 0) begin
        flag_mismatch("result with none due, channel", -1, int'(out_ch.chan_out));
      end else begin
        want = due_results.pop_front();
        if (out_ch.chan_out !== want.ch)
          flag_mismatch("chan_out", int'(want.ch), int'(out_ch.chan_out));
        if (out_ch.sample_out !== want.y)
          flag_mismatch("sample_out", int'(want.y), int'(out_ch.sample_out));
      end
    end
  end

  // output side: own stall pattern plus a long hold-off on request
  initial begin : receiver
    int unsigned tick;
    int unsigned hold_left;
    tick = 0;
    hold_left = 0;
    out_ch.ready <= 1'b0;
    while (!rst_n) @(posedge clk);
    forever begin
      @(posedge clk);
      tick++;
      if (hold_left != 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else if (hold_req) begin
        hold_req <= 1'b0;
        hold_left = 119;
        out_ch.ready <= 1'b0;
      end else begin
        case ((tick >> 7) % 4)
          0: out_ch.ready <= 1'b1;
          1: out_ch.ready <= ($urandom_range(0, 9) < 7);
          2: out_ch.ready <= (tick % 5 != 0) && (tick % 7 != 3);
          default: out_ch.ready <= ($urandom_range(0, 9) < 3);
        endcase
      end
    end
  end

  initial begin : watchdog
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("tb: failure");
    $finish;
  end

  initial begin : stimulus
    coef_t phase_e1 [N_PHASES];
    coef_t phase_e2 [N_PHASES];
    int burst_left;
    int gap;
    int no_gap_left;
    chan_t ch;
    phase_e1 = '{-18'sd78643, C_MAX, C_MIN, C_MIN, C_MAX, 18'sd0, '0, -18'sd32768, '0};
    phase_e2 = '{18'sd53084, C_MAX, C_MIN, C_MAX, C_MIN, 18'sd65536, '0, 18'sd16384, '0};
    phase_e1[6] = coef_t'($urandom);
    phase_e2[6] = coef_t'($urandom);
    phase_e1[8] = coef_t'($urandom);
    phase_e2[8] = coef_t'($urandom);
    burst_left = 0;
    no_gap_left = 0;
    ch = '0;
    for (int c = 0; c < CHANNELS; c++) begin
      in_z1[c] = '0;
      in_z2[c] = '0;
      out_z1[c] = '0;
      out_z2[c] = '0;
    end
    in_ch.valid     <= 1'b0;
    in_ch.chan      <= '0;
    in_ch.sample_in <= '0;
    cfg_we    <= 1'b0;
    cfg_idx   <= '0;
    cfg_wdata <= '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_tab[r]) push_item(dir_tab[r].ch, dir_tab[r].x, dir_tab[r].typed, dir_tab[r].y);

    for (int p = 0; p < N_PHASES; p++) begin
      wait_drain();
      repeat (4) @(posedge clk);
      write_coefs(phase_e1[p], phase_e2[p]);
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        if (p == 1 && i == 20) begin
          hold_req <= 1'b1;
          no_gap_left = 48;
        end
        if (p == 3 && i == 70) wait_drain();
        if (burst_left == 0) begin
          burst_left = $urandom_range(1, 24);
          gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
          if (no_gap_left == 0 && gap != 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
          end
        end
        burst_left--;
        if (no_gap_left != 0) no_gap_left--;
        // back-to-back on one channel exercises the y1 forwarding path
        if ($urandom_range(0, 99) >= 35) ch = chan_t'($urandom_range(0, CHANNELS - 1));
        push_item(ch, rand_sample(), 1'b0, '0);
      end
    end

    wait_drain();
    repeat (8) @(posedge clk);
    $display("covered %0d samples over %0d coefficient settings, %0d results checked",
             items_sent, N_PHASES + 1, results_seen);
    $display("incl. coefficient extremes, saturation, channel repeats, long output stall");
    if (mismatches == 0 && due_results.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

FILE: multichannel_allpass2_section_top.f
rtl/core/apf2_pkg.sv
rtl/core/apf2_if.sv
rtl/core/apf2_ram.sv
rtl/core/apf2_dp.sv
rtl/core/multichannel_allpass2_section_top.sv
rtl/core/apf2_checker.sv
tb/tb.sv
